// ===== sv/cfar_gwd_pkg.sv =====
package cfar_gwd_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_WIDTH    = 1024;
    localparam int DEF_MAX_HEIGHT   = 1024;
    localparam int DEF_SAMPLE_BITS  = 16;
    localparam int DEF_TRAIN_RADIUS = 2;

    // Fixed channel field widths
    localparam int SAMPLE_W   = 16;
    localparam int COORD_W    = 10;
    localparam int DIM_W      = 11;
    localparam int THRESH_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_Q  = 2'd2;

    // Reset values of the registers
    localparam logic [DIM_W-1:0]    RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [DIM_W-1:0]    RST_IMAGE_HEIGHT = 11'd1024;
    localparam logic [THRESH_W-1:0] RST_THRESHOLD_Q  = 16'd451;

    // Input operation codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Item sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COL,
        ST_STAT,
        ST_JUDGE,
        ST_PUSH
    } t_state;

endpackage

// ===== sv/cfar_gwd_if.sv =====
interface cfar_gwd_in_if import cfar_gwd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                op;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, op, sample, input ready);
    modport sink   (input valid, op, sample, output ready);
endinterface

interface cfar_gwd_out_if import cfar_gwd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic               detect;
    logic               frame_last;

    modport source (output valid, out_row, out_col, detect, frame_last, input ready);
    modport sink   (input valid, out_row, out_col, detect, frame_last, output ready);
endinterface

interface cfar_gwd_cfg_if import cfar_gwd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/cfar_gwd_line_store.sv =====
module cfar_gwd_line_store import cfar_gwd_pkg::*; #(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
    parameter int TRAIN_RADIUS = DEF_TRAIN_RADIUS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]           i_addr,
    input  logic [SAMPLE_BITS-1:0]                 i_x,
    output logic [2*TRAIN_RADIUS*SAMPLE_BITS-1:0]  o_word
);
    localparam int STORE_ROWS = 2 * TRAIN_RADIUS;
    localparam int WORD_W     = STORE_ROWS * SAMPLE_BITS;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);

    // One word per column: lane 0 is the oldest row, the top lane the newest
    logic [WORD_W-1:0]      mem [MAX_WIDTH];
    logic [WORD_W-1:0]      r_rdata;
    logic [ADDR_W-1:0]      r_addr;
    logic [SAMPLE_BITS-1:0] r_x;
    logic                   r_pend;
    logic [WORD_W-1:0]      n_word;

    // Column history moves down one lane, the new sample enters on top
    assign n_word = {r_x, r_rdata[WORD_W-1:SAMPLE_BITS]};
    assign o_word = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rdata <= mem[i_addr];
            r_addr  <= i_addr;
            r_x     <= i_x;
        end
    end

    // Write-back in the cycle after the read; the sequencer keeps reads apart
    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            mem[r_addr] <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= i_rd_en;
        end
    end

endmodule

// ===== sv/cfar_gwd_stats.sv =====
module cfar_gwd_stats import cfar_gwd_pkg::*; #(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
    parameter int TRAIN_RADIUS = DEF_TRAIN_RADIUS,
    parameter int N_W          = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [SAMPLE_BITS-1:0]              i_win [2*TRAIN_RADIUS+1][2*TRAIN_RADIUS+1],
    input  logic [$clog2(MAX_HEIGHT)-1:0]       i_row,
    input  logic [$clog2(MAX_WIDTH)-1:0]        i_col,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]     i_h,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]      i_w,
    output logic                                o_done,
    output logic [N_W-1:0]                      o_n,
    output logic [SAMPLE_BITS+N_W-1:0]          o_s,
    output logic [2*SAMPLE_BITS+N_W-1:0]        o_q,
    output logic [SAMPLE_BITS-1:0]              o_x
);
    localparam int WIN_SIDE = 2 * TRAIN_RADIUS + 1;
    localparam int K_W      = $clog2(WIN_SIDE);
    localparam int S_W      = SAMPLE_BITS + N_W;
    localparam int Q_W      = 2 * SAMPLE_BITS + N_W;

    logic                   r_busy;
    logic                   r_done;
    logic [K_W-1:0]         r_rr;
    logic [K_W-1:0]         r_kk;
    logic [N_W-1:0]         r_n;
    logic [S_W-1:0]         r_s;
    logic [Q_W-1:0]         r_q;
    logic                   w_guard;
    logic                   w_in_img;
    logic                   w_use;
    logic [SAMPLE_BITS-1:0] w_cell;
    logic                   w_last;

    // Guard block and image clipping for the cell under the walker
    assign w_guard = (32'(r_rr) >= 32'(TRAIN_RADIUS - 1)) && (32'(r_rr) <= 32'(TRAIN_RADIUS + 1))
                  && (32'(r_kk) >= 32'(TRAIN_RADIUS - 1)) && (32'(r_kk) <= 32'(TRAIN_RADIUS + 1));
    assign w_in_img = (32'(i_row) + 32'(r_rr) >= 32'(TRAIN_RADIUS))
                   && (32'(i_row) + 32'(r_rr) <  32'(i_h) + 32'(TRAIN_RADIUS))
                   && (32'(i_col) + 32'(r_kk) >= 32'(TRAIN_RADIUS))
                   && (32'(i_col) + 32'(r_kk) <  32'(i_w) + 32'(TRAIN_RADIUS));
    assign w_use  = !w_guard && w_in_img;
    assign w_cell = w_use ? i_win[r_rr][r_kk] : '0;
    assign w_last = (32'(r_rr) == 32'(WIN_SIDE - 1)) && (32'(r_kk) == 32'(WIN_SIDE - 1));

    // One cell per cycle: count, sum and sum of squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_rr   <= '0;
            r_kk   <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rr   <= '0;
                r_kk   <= '0;
            end else if (r_busy) begin
                if (w_last) begin
                    r_busy <= 1'b0;
                end
                if (32'(r_kk) == 32'(WIN_SIDE - 1)) begin
                    r_kk <= '0;
                    r_rr <= r_rr + K_W'(1);
                end else begin
                    r_kk <= r_kk + K_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n <= '0;
            r_s <= '0;
            r_q <= '0;
        end else if (r_busy) begin
            r_n <= r_n + N_W'(w_use);
            r_s <= r_s + S_W'(w_cell);
            r_q <= r_q + Q_W'(w_cell * w_cell);
        end
    end

    assign o_done = r_done;
    assign o_n    = r_n;
    assign o_s    = r_s;
    assign o_q    = r_q;
    assign o_x    = i_win[TRAIN_RADIUS][TRAIN_RADIUS];

endmodule

// ===== sv/cfar_gwd_judge.sv =====
module cfar_gwd_judge import cfar_gwd_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int N_W         = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [N_W-1:0]                i_n,
    input  logic [SAMPLE_BITS+N_W-1:0]    i_s,
    input  logic [2*SAMPLE_BITS+N_W-1:0]  i_q,
    input  logic [SAMPLE_BITS-1:0]        i_x,
    input  logic [THRESH_W-1:0]           i_t,
    output logic                          o_done,
    output logic                          o_det
);
    localparam int S_W    = SAMPLE_BITS + N_W;
    localparam int V_W    = 2 * S_W;
    localparam int VL_W   = V_W / 2;
    localparam int VH_W   = V_W - VL_W;
    localparam int T2_W   = 2 * THRESH_W - 1;
    localparam int LHS_W  = 2 * S_W + 16;
    localparam int RHS_W  = T2_W + V_W;
    localparam int CMP_W  = (RHS_W > LHS_W) ? RHS_W : LHS_W;
    localparam int STAGES = 7;

    logic [STAGES-1:0]          r_stg;
    // stage 1
    logic [V_W-1:0]             r_nq1;
    logic [S_W-1:0]             r_nx1;
    logic [S_W-1:0]             r_s1;
    // stage 2
    logic [V_W-1:0]             r_nq2;
    logic [V_W-1:0]             r_ss2;
    logic signed [S_W:0]        r_d2;
    logic [T2_W-1:0]            r_t2;
    // stage 3
    logic [V_W-1:0]             r_v3;
    logic [S_W-1:0]             r_mag3;
    logic                       r_dpos3, r_dneg3;
    // stage 4
    logic [T2_W+VL_W-1:0]       r_pl4;
    logic [VH_W-1:0]            r_vh4;
    logic [S_W-1:0]             r_mag4;
    logic                       r_dpos4, r_dneg4, r_vz4;
    // stage 5
    logic [T2_W+VH_W-1:0]       r_ph5;
    logic [T2_W+VL_W-1:0]       r_pl5;
    logic [S_W-1:0]             r_mag5;
    logic                       r_dpos5, r_dneg5, r_vz5;
    // stage 6
    logic [LHS_W-1:0]           r_lhs6;
    logic [RHS_W-1:0]           r_rhs6;
    logic                       r_dpos6, r_dneg6, r_vz6;
    // stage 7
    logic                       r_det;
    logic signed [2*THRESH_W-1:0] w_tt;
    logic                       w_gt, w_lt;

    assign w_tt = $signed(i_t) * $signed(i_t);
    assign w_gt = CMP_W'(r_lhs6) > CMP_W'(r_rhs6);
    assign w_lt = CMP_W'(r_lhs6) < CMP_W'(r_rhs6);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg <= '0;
        end else begin
            r_stg <= {r_stg[STAGES-2:0], i_start};
        end
    end

    // Exact test: 65536*d^2 against t^2*v, with the sign rules on d and t
    always_ff @(posedge i_clk) begin
        r_nq1   <= i_n * i_q;
        r_nx1   <= i_n * i_x;
        r_s1    <= i_s;

        r_nq2   <= r_nq1;
        r_ss2   <= r_s1 * r_s1;
        r_d2    <= $signed({1'b0, r_nx1}) - $signed({1'b0, r_s1});
        r_t2    <= T2_W'(w_tt);

        r_v3    <= r_nq2 - r_ss2;
        r_mag3  <= r_d2[S_W] ? S_W'(-r_d2) : r_d2[S_W-1:0];
        r_dpos3 <= !r_d2[S_W] && (r_d2 != '0);
        r_dneg3 <= r_d2[S_W];

        r_pl4   <= r_t2 * r_v3[VL_W-1:0];
        r_vh4   <= r_v3[V_W-1:VL_W];
        r_mag4  <= r_mag3;
        r_dpos4 <= r_dpos3;
        r_dneg4 <= r_dneg3;
        r_vz4   <= (r_v3 == '0);

        r_ph5   <= r_t2 * r_vh4;
        r_pl5   <= r_pl4;
        r_mag5  <= r_mag4;
        r_dpos5 <= r_dpos4;
        r_dneg5 <= r_dneg4;
        r_vz5   <= r_vz4;

        r_lhs6  <= {LHS_W'(r_mag5 * r_mag5)} << 16;
        r_rhs6  <= RHS_W'(r_pl5) + (RHS_W'(r_ph5) << VL_W);
        r_dpos6 <= r_dpos5;
        r_dneg6 <= r_dneg5;
        r_vz6   <= r_vz5;

        if (r_vz6) begin
            r_det <= r_dpos6;
        end else if (!i_t[THRESH_W-1]) begin
            r_det <= r_dpos6 && w_gt;
        end else begin
            r_det <= !r_dneg6 || w_lt;
        end
    end

    assign o_done = r_stg[STAGES-1];
    assign o_det  = r_det;

endmodule

// ===== sv/cfar_guard_window_detector.sv =====
// CA-CFAR detector over a raster image stream, training window of
// (2R+1)x(2R+1) cells with a 3x3 guard block, both clipped at the edges.
// Channels: i_in takes one beat per pixel (op = pixel) or drain step
// (op = drain); o_out gives one beat per judged centre pixel with its row,
// column, detect flag and frame_last; i_cfg writes image_width (0),
// image_height (1) and threshold_q (2, signed Q8.8). A size write starts a
// new frame. Configuration is always ready.
// Results lag the input by R*W+R raster positions; after the last pixel the
// same number of drain beats flushes them. Drains are ignored mid-frame or
// once the frame is flushed; a pixel after the frame end starts a new one.
// Throughput: one item at a time. A beat that yields no result passes
// through the column step only; one that yields a result then goes
// through the statistics unit, which walks the window one cell a cycle,
// the threshold test pipeline and the output push. The line store is
// read and written back once per beat.
// Reset clears positions, window and registers; line store content is not
// cleared. A stalled o_out holds its beat; the next input beat is still
// taken and its result waits in the sequencer until the output frees.
module cfar_guard_window_detector import cfar_gwd_pkg::*; #(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
    parameter int TRAIN_RADIUS = DEF_TRAIN_RADIUS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cfar_gwd_in_if.sink    i_in,
    cfar_gwd_out_if.source o_out,
    cfar_gwd_cfg_if.sink   i_cfg
);
    localparam int WIN_SIDE   = 2 * TRAIN_RADIUS + 1;
    localparam int STORE_ROWS = 2 * TRAIN_RADIUS;
    localparam int NCELL      = WIN_SIDE * WIN_SIDE - 9;
    localparam int N_W        = $clog2(NCELL + 1);
    localparam int S_W        = SAMPLE_BITS + N_W;
    localparam int Q_W        = 2 * SAMPLE_BITS + N_W;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WW         = $clog2(MAX_WIDTH + 1);
    localparam int HW         = $clog2(MAX_HEIGHT + 1);
    localparam int RROW_W     = $clog2(MAX_HEIGHT);
    localparam int IROW_W     = $clog2(MAX_HEIGHT + WIN_SIDE + 1);
    localparam int FILL_W     = $clog2(TRAIN_RADIUS * MAX_WIDTH + TRAIN_RADIUS + 1);

    t_state                 r_state, n_state;
    logic [DIM_W-1:0]       r_img_w, r_img_h;
    logic [THRESH_W-1:0]    r_thr;
    logic [IROW_W-1:0]      r_in_row;
    logic [COL_W-1:0]       r_in_col;
    logic [RROW_W-1:0]      r_res_row;
    logic [COL_W-1:0]       r_res_col;
    logic [FILL_W-1:0]      r_fill;
    logic                   r_done;
    logic                   r_emit;
    logic [SAMPLE_BITS-1:0] r_x;
    logic [SAMPLE_BITS-1:0] r_win [WIN_SIDE][WIN_SIDE];
    logic [RROW_W-1:0]      r_jrow;
    logic [COL_W-1:0]       r_jcol;
    logic                   r_jlast;
    logic                   r_det;
    logic                   r_out_vld;
    logic [COORD_W-1:0]     r_out_row, r_out_col;
    logic                   r_out_det, r_out_last;

    logic [WW-1:0]          w_w;
    logic [HW-1:0]          w_h;
    logic [FILL_W-1:0]      w_lag;
    logic                   w_acc, w_drain, w_wrap, w_restart, w_take;
    logic [IROW_W-1:0]      w_row0, n_in_row;
    logic [COL_W-1:0]       w_col0, n_in_col;
    logic [FILL_W-1:0]      w_fill0, n_fill;
    logic                   w_emit;
    logic [SAMPLE_BITS-1:0] w_x;
    logic                   w_cfg_acc, w_res_last;
    logic [STORE_ROWS*SAMPLE_BITS-1:0] w_word;
    logic [SAMPLE_BITS-1:0] w_column [WIN_SIDE];
    logic                   w_stat_start, w_stat_done, w_judge_done, w_judge_det;
    logic                   w_push;
    logic [N_W-1:0]         w_n;
    logic [S_W-1:0]         w_s;
    logic [Q_W-1:0]         w_q;
    logic [SAMPLE_BITS-1:0] w_cx;

    // Effective image size, clamped to 1..MAX
    always_comb begin
        if (r_img_w == '0) begin
            w_w = WW'(1);
        end else if (32'(r_img_w) > 32'(MAX_WIDTH)) begin
            w_w = WW'(MAX_WIDTH);
        end else begin
            w_w = WW'(r_img_w);
        end
        if (r_img_h == '0) begin
            w_h = HW'(1);
        end else if (32'(r_img_h) > 32'(MAX_HEIGHT)) begin
            w_h = HW'(MAX_HEIGHT);
        end else begin
            w_h = HW'(r_img_h);
        end
    end

    assign w_lag = FILL_W'(TRAIN_RADIUS) * FILL_W'(w_w) + FILL_W'(TRAIN_RADIUS);

    // Input beat decode
    assign i_in.ready = (r_state == ST_IDLE);
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_drain    = (i_in.op == OP_DRAIN);
    assign w_wrap     = 32'(r_in_row) >= 32'(w_h);
    assign w_restart  = !w_drain && w_wrap;
    assign w_take     = w_acc && (!w_drain || (w_wrap && !r_done));
    assign w_row0     = w_restart ? '0 : r_in_row;
    assign w_col0     = w_restart ? '0 : r_in_col;
    assign w_fill0    = w_restart ? '0 : r_fill;
    assign w_emit     = w_fill0 >= w_lag;
    assign n_fill     = w_emit ? w_fill0 : w_fill0 + FILL_W'(1);
    assign w_x        = w_drain ? '0 : i_in.sample[SAMPLE_BITS-1:0];

    always_comb begin
        if (32'(w_col0) + 32'd1 >= 32'(w_w)) begin
            n_in_col = '0;
            n_in_row = w_row0 + IROW_W'(1);
        end else begin
            n_in_col = w_col0 + COL_W'(1);
            n_in_row = w_row0;
        end
    end

    assign w_cfg_acc   = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;
    assign w_res_last  = (32'(r_res_row) + 32'd1 == 32'(w_h))
                      && (32'(r_res_col) + 32'd1 == 32'(w_w));

    // Line store: column history per image column
    cfar_gwd_line_store #(
        .MAX_WIDTH    (MAX_WIDTH),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .TRAIN_RADIUS (TRAIN_RADIUS)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (w_take),
        .i_addr  (w_col0),
        .i_x     (w_x),
        .o_word  (w_word)
    );

    // New window column: stored rows on top, current sample at the bottom
    always_comb begin
        for (int rr = 0; rr < STORE_ROWS; rr++) begin
            w_column[rr] = w_word[rr*SAMPLE_BITS +: SAMPLE_BITS];
        end
        w_column[STORE_ROWS] = r_x;
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_x <= w_x;
        end
    end

    // Control state, positions and window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_img_w   <= RST_IMAGE_WIDTH;
            r_img_h   <= RST_IMAGE_HEIGHT;
            r_thr     <= RST_THRESHOLD_Q;
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_res_row <= '0;
            r_res_col <= '0;
            r_fill    <= '0;
            r_done    <= 1'b0;
            r_emit    <= 1'b0;
            r_out_vld <= 1'b0;
            for (int rr = 0; rr < WIN_SIDE; rr++) begin
                for (int kk = 0; kk < WIN_SIDE; kk++) begin
                    r_win[rr][kk] <= '0;
                end
            end
        end else begin
            r_state <= n_state;

            if (w_cfg_acc) begin
                unique case (i_cfg.index)
                    REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT: begin
                        if (i_cfg.index == REG_IMAGE_WIDTH) begin
                            r_img_w <= i_cfg.data[DIM_W-1:0];
                        end else begin
                            r_img_h <= i_cfg.data[DIM_W-1:0];
                        end
                        r_in_row  <= '0;
                        r_in_col  <= '0;
                        r_res_row <= '0;
                        r_res_col <= '0;
                        r_fill    <= '0;
                        r_done    <= 1'b0;
                    end
                    REG_THRESHOLD_Q: r_thr <= i_cfg.data[THRESH_W-1:0];
                    default: ;
                endcase
            end

            if (w_take) begin
                r_in_row <= n_in_row;
                r_in_col <= n_in_col;
                r_fill   <= n_fill;
                r_emit   <= w_emit;
                if (w_restart) begin
                    r_res_row <= '0;
                    r_res_col <= '0;
                    r_done    <= 1'b0;
                end
            end

            if (r_state == ST_COL) begin
                for (int rr = 0; rr < WIN_SIDE; rr++) begin
                    for (int kk = 0; kk < WIN_SIDE - 1; kk++) begin
                        r_win[rr][kk] <= r_win[rr][kk+1];
                    end
                    r_win[rr][WIN_SIDE-1] <= w_column[rr];
                end
                if (r_emit) begin
                    if (w_res_last) begin
                        r_done <= 1'b1;
                    end
                    if (32'(r_res_col) + 32'd1 >= 32'(w_w)) begin
                        r_res_col <= '0;
                        r_res_row <= r_res_row + RROW_W'(1);
                    end else begin
                        r_res_col <= r_res_col + COL_W'(1);
                    end
                end
            end

            // Output register
            if (w_push) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Centre snapshot and result payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_COL && r_emit) begin
            r_jrow  <= r_res_row;
            r_jcol  <= r_res_col;
            r_jlast <= w_res_last;
        end
        if (w_judge_done) begin
            r_det <= w_judge_det;
        end
        if (w_push) begin
            r_out_row  <= COORD_W'(r_jrow);
            r_out_col  <= COORD_W'(r_jcol);
            r_out_det  <= r_det;
            r_out_last <= r_jlast;
        end
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        w_stat_start = 1'b0;
        w_push       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    n_state = ST_COL;
                end
            end
            ST_COL: begin
                if (r_emit) begin
                    w_stat_start = 1'b1;
                    n_state      = ST_STAT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_STAT: begin
                if (w_stat_done) begin
                    n_state = ST_JUDGE;
                end
            end
            ST_JUDGE: begin
                if (w_judge_done) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!r_out_vld || o_out.ready) begin
                    w_push  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    cfar_gwd_stats #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .TRAIN_RADIUS (TRAIN_RADIUS),
        .N_W          (N_W)
    ) u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_stat_start),
        .i_win   (r_win),
        .i_row   (r_jrow),
        .i_col   (r_jcol),
        .i_h     (w_h),
        .i_w     (w_w),
        .o_done  (w_stat_done),
        .o_n     (w_n),
        .o_s     (w_s),
        .o_q     (w_q),
        .o_x     (w_cx)
    );

    cfar_gwd_judge #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .N_W         (N_W)
    ) u_judge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_stat_done),
        .i_n     (w_n),
        .i_s     (w_s),
        .i_q     (w_q),
        .i_x     (w_cx),
        .i_t     (r_thr),
        .o_done  (w_judge_done),
        .o_det   (w_judge_det)
    );

    assign o_out.valid      = r_out_vld;
    assign o_out.out_row    = r_out_row;
    assign o_out.out_col    = r_out_col;
    assign o_out.detect     = r_out_det;
    assign o_out.frame_last = r_out_last;

`ifndef SYNTHESIS
    ap_stat_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat_done |-> (r_state == ST_STAT))
        else $error("statistics finished outside the statistics phase");

    ap_judge_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_judge_done |-> (r_state == ST_JUDGE))
        else $error("threshold test finished outside the test phase");

    ap_push_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUSH && r_out_vld && !o_out.ready) |=> (r_state == ST_PUSH))
        else $error("result left the sequencer while the output was stalled");
`endif

endmodule
